/* hw/rtl/pac_pkg.sv */
`default_nettype none

package pac_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int COORD_BITS_DEF   = 16;
    localparam int CROSS_BITS       = 40;
    localparam int MOMENT_BITS      = 56;
    // Three times a signed cross sum needs two more bits.
    localparam int DEN_BITS         = CROSS_BITS + 2;
    localparam int DIV_CNT_BITS     = $clog2(MOMENT_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_E0,
        S_E1,
        S_E2,
        S_E3,
        S_E4,
        S_E5,
        S_FIN,
        S_DX,
        S_DXW,
        S_DY,
        S_DYW,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                   start;
        logic [MOMENT_BITS-1:0] dividend;
        logic [DEN_BITS-1:0]    divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [MOMENT_BITS-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

/* hw/rtl/pac_vertex_if.sv */
`default_nettype none

interface pac_vertex_if #(
    parameter int COORD_BITS = pac_pkg::COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] vertex_x;
    logic signed [COORD_BITS-1:0] vertex_y;
    logic                         last_vertex;

    modport source (output valid, output vertex_x, output vertex_y, output last_vertex,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input last_vertex,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/pac_result_if.sv */
`default_nettype none

interface pac_result_if #(
    parameter int COORD_BITS = pac_pkg::COORD_BITS_DEF
) ();
    logic                                  valid;
    logic                                  ready;
    logic signed [pac_pkg::CROSS_BITS-1:0] double_area;
    logic signed [COORD_BITS-1:0]          center_x;
    logic signed [COORD_BITS-1:0]          center_y;
    logic                                  degenerate;

    modport source (output valid, output double_area, output center_x, output center_y,
                    output degenerate, input ready);
    modport sink (input valid, input double_area, input center_x, input center_y,
                  input degenerate, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pac_mul.sv */
`default_nettype none

module pac_mul #(
    parameter int A_W = pac_pkg::COORD_BITS_DEF + 1,
    parameter int B_W = 2 * pac_pkg::COORD_BITS_DEF + 1
) (
    input  wire logic                     i_clk,
    input  wire logic signed [A_W-1:0]    i_a,
    input  wire logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0]     o_p
);

    logic signed [A_W+B_W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

/* hw/rtl/pac_div.sv */
`default_nettype none

module pac_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pac_pkg::t_div_req i_req,
    output pac_pkg::t_div_rsp      o_rsp
);

    localparam int NW = pac_pkg::MOMENT_BITS;
    localparam int DW = pac_pkg::DEN_BITS;
    localparam int CW = pac_pkg::DIV_CNT_BITS;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   w_shift;
    logic [DW+1:0] w_diff;
    logic          w_borrow;
    logic [DW-1:0] n_rem;

    // One restoring step a cycle: the dividend shifts out of r_quo as quotient bits shift in.
    always_comb begin
        w_shift  = {r_rem, r_quo[NW-1]};
        w_diff   = {1'b0, w_shift} - {2'b00, r_dvs};
        w_borrow = w_diff[DW+1];
        n_rem    = w_borrow ? w_shift[DW-1:0] : w_diff[DW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[NW-2:0], ~w_borrow};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

`default_nettype wire

/* hw/rtl/polygon_area_centroid.sv */
`default_nettype none

// Shoelace area and centroid of a polygon streamed in one vertex per beat, the last beat
// flagged. Each edge takes its four products on one shared registered multiplier, so a
// vertex after the first keeps the input stalled while its edge runs through S_E0 to S_E5.
// The last vertex also adds the closing edge. The centroid then comes from two 56-step
// divisions on one shared bit-serial divider, and the result beat is loaded from S_OUT;
// a degenerate polygon skips the divisions and goes from S_FIN straight to S_OUT. The
// result register lets a new polygon start while the previous result waits to be taken.
// The block clears itself after every result.
module polygon_area_centroid #(
    parameter int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF,
    parameter int COORD_BITS   = pac_pkg::COORD_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    pac_vertex_if.sink    i_vtx,
    pac_result_if.source  o_res
);

    localparam int CB    = COORD_BITS;
    localparam int AW    = CB + 1;
    localparam int XW    = 2 * CB + 1;
    localparam int PW    = AW + XW;
    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int EXT_W = 128;
    localparam int MB    = pac_pkg::MOMENT_BITS;
    localparam int XB    = pac_pkg::CROSS_BITS;
    localparam int DB    = pac_pkg::DEN_BITS;
    localparam int QHW   = MB - CB + 1;

    pac_pkg::t_state r_state, n_state;

    logic signed [CB-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic [CNT_W-1:0]     r_count;
    logic [XB-1:0]        r_cross_sum;
    logic [MB-1:0]        r_mx, r_my;
    logic                 r_last, r_closing;

    logic signed [CB-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [AW-1:0] r_sx, r_sy;
    logic [XW-1:0]        r_p1;
    logic signed [XW-1:0] r_cross;
    logic signed [DB-1:0] r_den;
    logic                 r_qneg;
    logic signed [CB-1:0] r_cx, r_cy;
    logic                 r_degen;

    logic                 r_out_valid;
    logic [XB-1:0]        r_o_area;
    logic signed [CB-1:0] r_o_cx, r_o_cy;
    logic                 r_o_degen;

    logic                 w_ready, w_accept, w_degen, w_out_load;
    logic signed [AW-1:0] w_mul_a;
    logic signed [XW-1:0] w_mul_b;
    logic signed [PW-1:0] w_mul_p;
    logic signed [EXT_W-1:0] w_cross_ext, w_prod_ext;
    logic signed [DB-1:0] w_den_ext;
    logic [MB-1:0]        w_mx_mag, w_my_mag;
    logic [DB-1:0]        w_den_mag;
    pac_pkg::t_div_req    w_div_req;
    pac_pkg::t_div_rsp    w_div_rsp;
    logic [MB-1:0]        w_q;
    logic [QHW-1:0]       w_q_hi;
    logic                 w_pos_ovf, w_neg_ovf;
    logic signed [CB-1:0] w_sat;

    pac_mul #(
        .A_W (AW),
        .B_W (XW)
    ) u_pac_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (w_mul_p)
    );

    pac_div u_pac_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_accept    = i_vtx.valid && w_ready;
    assign w_degen     = (r_count < CNT_W'(3)) || (r_cross_sum == '0);
    assign w_out_load  = !r_out_valid || o_res.ready;
    assign w_cross_ext = EXT_W'(r_cross);
    assign w_prod_ext  = EXT_W'(w_mul_p);
    assign w_den_ext   = DB'(signed'(r_cross_sum));
    assign w_mx_mag    = r_mx[MB-1] ? (~r_mx + MB'(1)) : r_mx;
    assign w_my_mag    = r_my[MB-1] ? (~r_my + MB'(1)) : r_my;
    assign w_den_mag   = r_den[DB-1] ? (~r_den + DB'(1)) : r_den;

    // Quotients are magnitudes; the sign is applied while saturating to the coordinate range.
    always_comb begin
        w_q       = w_div_rsp.quotient;
        w_q_hi    = w_q[MB-1:CB-1];
        w_pos_ovf = |w_q_hi;
        w_neg_ovf = (w_q_hi > QHW'(1)) || ((w_q_hi == QHW'(1)) && (|w_q[CB-2:0]));
        if (r_qneg) begin
            w_sat = w_neg_ovf ? {1'b1, {(CB-1){1'b0}}} : -w_q[CB-1:0];
        end else begin
            w_sat = w_pos_ovf ? {1'b0, {(CB-1){1'b1}}} : w_q[CB-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            pac_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (r_count != '0) begin
                        n_state = pac_pkg::S_E0;
                    end else if (i_vtx.last_vertex) begin
                        n_state = pac_pkg::S_FIN;
                    end
                end
            end
            pac_pkg::S_E0: n_state = pac_pkg::S_E1;
            pac_pkg::S_E1: n_state = pac_pkg::S_E2;
            pac_pkg::S_E2: n_state = pac_pkg::S_E3;
            pac_pkg::S_E3: n_state = pac_pkg::S_E4;
            pac_pkg::S_E4: n_state = pac_pkg::S_E5;
            pac_pkg::S_E5: begin
                if (r_last && !r_closing) begin
                    n_state = pac_pkg::S_E0;
                end else if (r_last) begin
                    n_state = pac_pkg::S_FIN;
                end else begin
                    n_state = pac_pkg::S_IDLE;
                end
            end
            pac_pkg::S_FIN: n_state = w_degen ? pac_pkg::S_OUT : pac_pkg::S_DX;
            pac_pkg::S_DX:  n_state = pac_pkg::S_DXW;
            pac_pkg::S_DXW: if (w_div_rsp.done) n_state = pac_pkg::S_DY;
            pac_pkg::S_DY:  n_state = pac_pkg::S_DYW;
            pac_pkg::S_DYW: if (w_div_rsp.done) n_state = pac_pkg::S_OUT;
            pac_pkg::S_OUT: if (w_out_load) n_state = pac_pkg::S_IDLE;
            default:        n_state = pac_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        w_ready            = 1'b0;
        w_mul_a            = AW'(r_ax);
        w_mul_b            = XW'(r_by);
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_mx_mag;
        w_div_req.divisor  = w_den_mag;
        case (r_state)
            pac_pkg::S_IDLE: w_ready = 1'b1;
            pac_pkg::S_E1: begin
                w_mul_a = AW'(r_bx);
                w_mul_b = XW'(r_ay);
            end
            pac_pkg::S_E3: begin
                w_mul_a = r_sx;
                w_mul_b = r_cross;
            end
            pac_pkg::S_E4: begin
                w_mul_a = r_sy;
                w_mul_b = r_cross;
            end
            pac_pkg::S_DX: w_div_req.start = 1'b1;
            pac_pkg::S_DY: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = w_my_mag;
            end
            default: w_ready = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pac_pkg::S_IDLE;
            r_first_x   <= '0;
            r_first_y   <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_count     <= '0;
            r_cross_sum <= '0;
            r_mx        <= '0;
            r_my        <= '0;
            r_last      <= 1'b0;
            r_closing   <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                pac_pkg::S_IDLE: begin
                    if (w_accept) begin
                        if (r_count == '0) begin
                            r_first_x <= i_vtx.vertex_x;
                            r_first_y <= i_vtx.vertex_y;
                        end
                        r_prev_x  <= i_vtx.vertex_x;
                        r_prev_y  <= i_vtx.vertex_y;
                        r_last    <= i_vtx.last_vertex;
                        r_closing <= 1'b0;
                        if (r_count < CNT_W'(MAX_VERTICES)) begin
                            r_count <= r_count + CNT_W'(1);
                        end
                    end
                end
                pac_pkg::S_E3: r_cross_sum <= r_cross_sum + w_cross_ext[XB-1:0];
                pac_pkg::S_E4: r_mx <= r_mx + w_prod_ext[MB-1:0];
                pac_pkg::S_E5: begin
                    r_my <= r_my + w_prod_ext[MB-1:0];
                    if (r_last) begin
                        r_closing <= 1'b1;
                    end
                end
                pac_pkg::S_OUT: begin
                    if (w_out_load) begin
                        r_first_x   <= '0;
                        r_first_y   <= '0;
                        r_prev_x    <= '0;
                        r_prev_y    <= '0;
                        r_count     <= '0;
                        r_cross_sum <= '0;
                        r_mx        <= '0;
                        r_my        <= '0;
                        r_last      <= 1'b0;
                        r_closing   <= 1'b0;
                    end
                end
                default: r_closing <= r_closing;
            endcase
        end
    end

    // Edge operands, intermediate products, the denominator and the centroid results.
    always_ff @(posedge i_clk) begin
        case (r_state)
            pac_pkg::S_IDLE: begin
                r_ax <= r_prev_x;
                r_ay <= r_prev_y;
                r_bx <= i_vtx.vertex_x;
                r_by <= i_vtx.vertex_y;
                r_sx <= AW'(r_prev_x) + AW'(i_vtx.vertex_x);
                r_sy <= AW'(r_prev_y) + AW'(i_vtx.vertex_y);
            end
            pac_pkg::S_E1: r_p1 <= w_mul_p[XW-1:0];
            pac_pkg::S_E2: r_cross <= r_p1 - w_mul_p[XW-1:0];
            pac_pkg::S_E5: begin
                // The closing edge runs from the last vertex back to the first one.
                r_ax <= r_prev_x;
                r_ay <= r_prev_y;
                r_bx <= r_first_x;
                r_by <= r_first_y;
                r_sx <= AW'(r_prev_x) + AW'(r_first_x);
                r_sy <= AW'(r_prev_y) + AW'(r_first_y);
            end
            pac_pkg::S_FIN: begin
                r_den   <= w_den_ext + (w_den_ext <<< 1);
                r_degen <= w_degen;
                r_cx    <= '0;
                r_cy    <= '0;
            end
            pac_pkg::S_DX:  r_qneg <= r_mx[MB-1] ^ r_den[DB-1];
            pac_pkg::S_DXW: if (w_div_rsp.done) r_cx <= w_sat;
            pac_pkg::S_DY:  r_qneg <= r_my[MB-1] ^ r_den[DB-1];
            pac_pkg::S_DYW: if (w_div_rsp.done) r_cy <= w_sat;
            default:        r_p1 <= r_p1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == pac_pkg::S_OUT) && w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == pac_pkg::S_OUT) && w_out_load) begin
            r_o_area  <= r_cross_sum;
            r_o_cx    <= r_cx;
            r_o_cy    <= r_cy;
            r_o_degen <= r_degen;
        end
    end

    assign i_vtx.ready       = w_ready;
    assign o_res.valid       = r_out_valid;
    assign o_res.double_area = r_o_area;
    assign o_res.center_x    = r_o_cx;
    assign o_res.center_y    = r_o_cy;
    assign o_res.degenerate  = r_o_degen;

endmodule

`default_nettype wire

/* hw/rtl/pac_checker.sv */
`default_nettype none

module pac_checker #(
    parameter int COORD_BITS = pac_pkg::COORD_BITS_DEF
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_in_last,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [pac_pkg::CROSS_BITS-1:0] i_double_area,
    input wire logic [COORD_BITS-1:0]         i_center_x,
    input wire logic [COORD_BITS-1:0]         i_center_y,
    input wire logic                          i_degenerate
);

    // A stalled result beat keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_double_area)
            && $stable(i_center_x) && $stable(i_center_y) && $stable(i_degenerate))
        else $error("result beat changed while stalled");

    // The last vertex always sends the block out of idle, so the input stalls next.
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("input ready right after a last vertex");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> (i_center_x == '0) && (i_center_y == '0))
        else $error("degenerate result with a nonzero centroid");

    a_area_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_degenerate |-> (i_double_area != '0))
        else $error("zero area not flagged as degenerate");

    // A new result is loaded only from the finishing step, when no vertex is taken.
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while input was ready");

endmodule

bind polygon_area_centroid pac_checker #(
    .COORD_BITS (COORD_BITS)
) u_pac_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_vtx.valid),
    .i_in_ready    (i_vtx.ready),
    .i_in_last     (i_vtx.last_vertex),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_double_area (o_res.double_area),
    .i_center_x    (o_res.center_x),
    .i_center_y    (o_res.center_y),
    .i_degenerate  (o_res.degenerate)
);

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;

    localparam int COORD_BITS   = pac_pkg::COORD_BITS_DEF;
    localparam int MAX_VERTICES = pac_pkg::MAX_VERTICES_DEF;
    localparam int HOLD_CYCLES  = 1500;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = 200;

    localparam logic signed [COORD_BITS-1:0] CMAX = 16'sh7fff;
    localparam logic signed [COORD_BITS-1:0] CMIN = 16'sh8000;

    typedef enum int {
        PH_STEADY,
        PH_SRC_IDLE,
        PH_SINK_STALL,
        PH_BOTH_IDLE
    } t_phase;

    typedef struct packed {
        logic signed [pac_pkg::CROSS_BITS-1:0] double_area;
        logic signed [COORD_BITS-1:0]          center_x;
        logic signed [COORD_BITS-1:0]          center_y;
        logic                                  degenerate;
    } t_poly_result;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic                         last;
        logic                         typed;
        t_poly_result                 want;
    } t_vertex_row;

    localparam t_poly_result NONE     = '0;
    localparam t_poly_result FLAT     = '{double_area: 0, center_x: 0, center_y: 0,
                                          degenerate: 1'b1};
    localparam t_poly_result UNIT_TRI = '{double_area: 1, center_x: 0, center_y: 0,
                                          degenerate: 1'b0};

    // Rows with typed set carry their result; the rest are checked against the predictor.
    localparam t_vertex_row DIRECTED_ROWS [24] = '{
        '{16'sd0,   16'sd0,   1'b1, 1'b1, FLAT},     // one vertex, right after reset
        '{CMAX,     CMAX,     1'b0, 1'b0, NONE},     // two vertices
        '{CMIN,     CMIN,     1'b1, 1'b1, FLAT},
        '{16'sd0,   16'sd0,   1'b0, 1'b0, NONE},     // unit triangle
        '{16'sd1,   16'sd0,   1'b0, 1'b0, NONE},
        '{16'sd0,   16'sd1,   1'b1, 1'b1, UNIT_TRI},
        '{16'sd0,   16'sd0,   1'b0, 1'b0, NONE},     // three collinear vertices
        '{16'sd1,   16'sd1,   1'b0, 1'b0, NONE},
        '{16'sd2,   16'sd2,   1'b1, 1'b1, FLAT},
        '{CMIN,     CMIN,     1'b0, 1'b0, NONE},     // full-range triangle
        '{CMAX,     CMIN,     1'b0, 1'b0, NONE},
        '{CMAX,     CMAX,     1'b1, 1'b0, NONE},
        '{CMIN,     CMIN,     1'b0, 1'b0, NONE},     // full-range square, clockwise
        '{CMIN,     CMAX,     1'b0, 1'b0, NONE},
        '{CMAX,     CMAX,     1'b0, 1'b0, NONE},
        '{CMAX,     CMIN,     1'b1, 1'b0, NONE},
        '{CMIN,     CMIN,     1'b0, 1'b0, NONE},     // bowtie with a tiny net area
        '{CMIN,     CMAX,     1'b0, 1'b0, NONE},
        '{CMAX,     CMIN,     1'b0, 1'b0, NONE},
        '{CMAX,     16'sd32766, 1'b1, 1'b0, NONE},
        '{-16'sd10, -16'sd10, 1'b0, 1'b0, NONE},     // negative centroid, truncation
        '{-16'sd3,  -16'sd10, 1'b0, 1'b0, NONE},
        '{-16'sd3,  -16'sd4,  1'b0, 1'b0, NONE},
        '{-16'sd10, -16'sd4,  1'b1, 1'b0, NONE}
    };

    logic clk;
    logic rst_n;

    pac_vertex_if #(.COORD_BITS(COORD_BITS)) vtx_if ();
    pac_result_if #(.COORD_BITS(COORD_BITS)) res_if ();

    polygon_area_centroid #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_BITS  (COORD_BITS)
    ) u_top (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_vtx  (vtx_if),
        .o_res  (res_if)
    );

    // Running state of the polygon as the block should see it.
    logic signed [COORD_BITS-1:0]    first_x, first_y, prev_x, prev_y;
    logic [8:0]                      vtx_count;
    logic [pac_pkg::CROSS_BITS-1:0]  cross_acc;
    logic [pac_pkg::MOMENT_BITS-1:0] mom_x_acc, mom_y_acc;

    t_poly_result polygon_results_due [$];
    int           mismatch_count;
    int           phase_items;
    int           src_idle_pct;
    int           sink_stall_pct;
    bit           hold_request;
    bit           hold_started;
    int           hold_left;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_polygon();
        first_x   = '0;
        first_y   = '0;
        prev_x    = '0;
        prev_y    = '0;
        vtx_count = '0;
        cross_acc = '0;
        mom_x_acc = '0;
        mom_y_acc = '0;
    endfunction

    function automatic void accumulate_edge(input longint ax, input longint ay,
                                            input longint bx, input longint by);
        longint cross_val;
        longint mx;
        longint my;
        cross_val = ax * by - bx * ay;
        mx        = (ax + bx) * cross_val;
        my        = (ay + by) * cross_val;
        cross_acc = cross_acc + cross_val[pac_pkg::CROSS_BITS-1:0];
        mom_x_acc = mom_x_acc + mx[pac_pkg::MOMENT_BITS-1:0];
        mom_y_acc = mom_y_acc + my[pac_pkg::MOMENT_BITS-1:0];
    endfunction

    function automatic logic signed [COORD_BITS-1:0] clamp_coord(input longint v);
        if (v > longint'(CMAX)) return CMAX;
        if (v < longint'(CMIN)) return CMIN;
        return v[COORD_BITS-1:0];
    endfunction

    function automatic bit predict_vertex(input logic signed [COORD_BITS-1:0] x,
                                          input logic signed [COORD_BITS-1:0] y,
                                          input logic last, output t_poly_result res);
        longint area2;
        longint den;
        res = '0;
        if (vtx_count == 0) begin
            first_x = x;
            first_y = y;
        end else begin
            accumulate_edge(prev_x, prev_y, x, y);
        end
        prev_x = x;
        prev_y = y;
        if (vtx_count < MAX_VERTICES) vtx_count++;
        if (!last) return 1'b0;

        accumulate_edge(x, y, first_x, first_y);
        area2 = longint'($signed(cross_acc));
        res.double_area = cross_acc;
        res.degenerate  = (vtx_count < 3) || (area2 == 0);
        if (!res.degenerate) begin
            den = 3 * area2;
            // Signed division in SystemVerilog truncates toward zero.
            res.center_x = clamp_coord(longint'($signed(mom_x_acc)) / den);
            res.center_y = clamp_coord(longint'($signed(mom_y_acc)) / den);
        end
        clear_polygon();
        return 1'b1;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_vertex(input logic signed [COORD_BITS-1:0] x,
                               input logic signed [COORD_BITS-1:0] y,
                               input logic last, input logic typed,
                               input t_poly_result want);
        t_poly_result predicted;
        while ($urandom_range(99) < src_idle_pct) begin
            vtx_if.valid <= 1'b0;
            @(negedge clk);
        end
        vtx_if.valid       <= 1'b1;
        vtx_if.vertex_x    <= x;
        vtx_if.vertex_y    <= y;
        vtx_if.last_vertex <= last;
        @(posedge clk);
        while (vtx_if.ready !== 1'b1) @(posedge clk);
        if (predict_vertex(x, y, last, predicted))
            polygon_results_due.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_extreme();
        case ($urandom_range(4))
            0:       return CMIN;
            1:       return CMAX;
            2:       return -16'sd1;
            3:       return 16'sd1;
            default: return 16'sd0;
        endcase
    endfunction

    task automatic send_random_polygon();
        int                           n;
        int                           kind;
        int                           pick;
        int                           dx;
        int                           dy;
        logic signed [COORD_BITS-1:0] bx, by, x, y;
        pick = $urandom_range(99);
        if (pick < 4)       n = 1;
        else if (pick < 8)  n = 2;
        else if (pick < 90) n = $urandom_range(3, 8);
        else                n = $urandom_range(9, 24);
        kind = $urandom_range(9);
        bx   = 16'($urandom);
        by   = 16'($urandom);
        dx   = $urandom_range(6) - 3;
        dy   = $urandom_range(6) - 3;
        for (int k = 0; k < n; k++) begin
            if (kind < 5) begin
                x = 16'($urandom);
                y = 16'($urandom);
            end else if (kind < 7) begin
                x = 16'($urandom_range(16) - 8);
                y = 16'($urandom_range(16) - 8);
            end else if (kind < 9) begin
                x = pick_extreme();
                y = pick_extreme();
            end else begin
                // Points on one line give a zero area.
                x = 16'(int'(bx) + k * dx);
                y = 16'(int'(by) + k * dy);
            end
            send_vertex(x, y, k == n - 1, 1'b0, NONE);
            phase_items++;
        end
    endtask

    // Winds around the full-range square many times, so the vertex count saturates
    // and the cross sum wraps.
    task automatic send_wound_polygon(input int n);
        logic signed [COORD_BITS-1:0] x, y;
        for (int k = 0; k < n; k++) begin
            x = (k % 4 == 0 || k % 4 == 3) ? CMAX : -CMAX;
            y = (k % 4 < 2) ? CMAX : -CMAX;
            send_vertex(x, y, k == n - 1, 1'b0, NONE);
        end
    endtask

    always @(negedge clk) begin
        if (hold_request && !hold_started) begin
            hold_left    = HOLD_CYCLES;
            hold_started = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk) begin
        t_poly_result seen;
        t_poly_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            seen = '{res_if.double_area, res_if.center_x, res_if.center_y, res_if.degenerate};
            if (polygon_results_due.size() == 0) begin
                if (mismatch_count < 10)
                    $display("unexpected result: area %0d center (%0d, %0d) degenerate %0b",
                             seen.double_area, seen.center_x, seen.center_y, seen.degenerate);
                mismatch_count++;
            end else begin
                want = polygon_results_due.pop_front();
                if (seen !== want) begin
                    if (mismatch_count < 10)
                        $display("mismatch: expected area %0d center (%0d, %0d) degen %0b, %s",
                                 want.double_area, want.center_x, want.center_y,
                                 want.degenerate, "got:");
                    if (mismatch_count < 10)
                        $display("          actual   area %0d center (%0d, %0d) degen %0b",
                                 seen.double_area, seen.center_x, seen.center_y,
                                 seen.degenerate);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        vtx_if.valid       = 1'b0;
        vtx_if.vertex_x    = '0;
        vtx_if.vertex_y    = '0;
        vtx_if.last_vertex = 1'b0;
        res_if.ready       = 1'b0;
        mismatch_count     = 0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        hold_request       = 1'b0;
        hold_started       = 1'b0;
        hold_left          = 0;
        clear_polygon();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < $size(DIRECTED_ROWS); r++)
            send_vertex(DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y, DIRECTED_ROWS[r].last,
                        DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        for (int p = PH_STEADY; p <= PH_BOTH_IDLE; p++) begin
            case (t_phase'(p))
                PH_STEADY:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                PH_SRC_IDLE:   begin src_idle_pct = 88; sink_stall_pct = 0;  end
                PH_SINK_STALL: begin src_idle_pct = 0;  sink_stall_pct = 88; end
                default:       begin src_idle_pct = 33; sink_stall_pct = 33; end
            endcase
            if (t_phase'(p) == PH_STEADY) send_wound_polygon(300);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) send_random_polygon();
            if (t_phase'(p) == PH_STEADY) begin
                // The receiver goes quiet while vertices keep coming, so the result
                // register and then the input back up.
                hold_request = 1'b1;
                phase_items  = 0;
                while (phase_items < 40) send_random_polygon();
            end
        end

        vtx_if.valid <= 1'b0;
        while (polygon_results_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && polygon_results_due.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
